/* rtl/rgbcc_pkg.sv */
package rgbcc_pkg;

	// Sizes of the pixel stream and of the frame geometry.
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W = 8;
	localparam int CHANNELS = 3;
	localparam int TAPS = 3;
	localparam int PIX_MAX = 255;
	localparam int DIM_W = 11;
	localparam int ACC_W = 16;

	// Configuration port layout.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

	localparam logic [DIM_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd600;

	// Item kinds on the pixel channel.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// One RGB pixel, red in the low byte.
	typedef logic [CHANNELS*PIX_W-1:0] rgb_t;

	// Three kernel rows of three signed coefficients, left column in the low byte.
	typedef logic [TAPS-1:0][TAPS*PIX_W-1:0] kernel_t;

	// 3x3 window: [row][column], row 0 is the row above, column 0 is the left.
	typedef logic [TAPS-1:0][TAPS-1:0][CHANNELS*PIX_W-1:0] window_t;

	// Tap masking and result flags for one window position.
	typedef struct packed {
		logic res;
		logic top_off;
		logic bot_off;
		logic left_off;
		logic right_off;
		logic last;
	} tap_ctl_t;

	// One finished result.
	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic frame_last;
	} res_t;

	// Signed coefficient times unsigned pixel, kept modulo 2^16.
	function automatic logic [ACC_W-1:0] mul_tap(input logic [PIX_W-1:0] coef,
		input logic [PIX_W-1:0] pix);
		logic signed [2*PIX_W:0] prod;
		prod = $signed(coef) * $signed({1'b0, pix});
		return prod[ACC_W-1:0];
	endfunction

	// Negative sums go to zero, large ones saturate at full scale.
	function automatic logic [PIX_W-1:0] clamp_pix(input logic [ACC_W-1:0] acc);
		logic [PIX_W-1:0] pix;
		if (acc[ACC_W-1]) begin
			pix = '0;
		end else if (acc[ACC_W-2:PIX_W] != '0) begin
			pix = PIX_MAX[PIX_W-1:0];
		end else begin
			pix = acc[PIX_W-1:0];
		end
		return pix;
	endfunction

endpackage

/* rtl/rgbcc_ifs.sv */
// Pixel input channel.
interface rgbcc_pix_if import rgbcc_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	logic [PIX_W-1:0] pix_red;
	logic [PIX_W-1:0] pix_green;
	logic [PIX_W-1:0] pix_blue;

	modport source(output valid, func, pix_red, pix_green, pix_blue, input ready);
	modport sink(input valid, func, pix_red, pix_green, pix_blue, output ready);
endinterface

// Result output channel.
interface rgbcc_res_if import rgbcc_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic frame_last;

	modport source(output valid, out_red, out_green, out_blue, frame_last, input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// Configuration write channel.
interface rgbcc_cfg_if import rgbcc_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/rgb_3x3_convolution_clamp_core.sv */
// A result comes out of the last pipeline stage after the transaction of the pixel
// that completes its window (one row plus one column after its centre pixel).
// Throughput: one pixel transaction per clock without output backpressure; the four
// stages (line store read, window, products, sum and clamp) stall only on backpressure.
// Reset: kernel zero, 1024 x 600 frame, position and window cleared, pipeline empty;
// the line stores are not cleared, so the block accepts pixels right after reset.
module rgb_3x3_convolution_clamp_core import rgbcc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rgbcc_pix_if.sink   pixel,
	rgbcc_res_if.source result,
	rgbcc_cfg_if.sink   cfg
);

	localparam int CW = $clog2(MAX_WIDTH);

	kernel_t          kernel;
	logic [CW-1:0]    col;
	logic [CW:0]      w_eff;
	logic [DIM_W-1:0] row;
	logic [DIM_W-1:0] h_eff;
	tap_ctl_t         ctl;
	tap_ctl_t         ctl_s2;
	window_t          window;
	rgb_t             pix;
	res_t             res;
	logic             s1_v;
	logic             s2_v;
	logic             s3_v;
	logic             out_v_q;
	logic             out_free;
	logic             can_s3;
	logic             can_s2;
	logic             can_s1;
	logic             accept;
	logic             s1_shift;

	// Pipeline flow: each stage moves on when the one after it is free or moving.
	assign out_free = !out_v_q || result.ready;
	assign can_s3 = !s3_v || out_free;
	assign can_s2 = !s2_v || can_s3;
	assign can_s1 = !s1_v || can_s2;
	assign accept = pixel.valid && can_s1;
	assign s1_shift = s1_v && can_s2;
	assign pixel.ready = can_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (can_s1) begin
				s1_v <= accept;
			end
			if (can_s2) begin
				s2_v <= s1_v;
			end
			// Items whose window has no centre inside the frame end here.
			if (can_s3) begin
				s3_v <= s2_v && ctl_s2.res;
			end
			if (out_free) begin
				out_v_q <= s3_v;
			end
		end
	end

	// A drain transaction enters the window as a black pixel.
	assign pix = (pixel.func == FUNC_DRAIN) ? '0 :
		{pixel.pix_blue, pixel.pix_green, pixel.pix_red};

	rgbcc_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.accept(accept),
		.kernel(kernel),
		.col   (col),
		.w_eff (w_eff),
		.row   (row),
		.h_eff (h_eff),
		.ctl   (ctl)
	);

	rgbcc_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.s1_v    (s1_v),
		.s1_shift(s1_shift),
		.col     (col),
		.pix     (pix),
		.ctl     (ctl),
		.window  (window),
		.ctl_s2  (ctl_s2)
	);

	rgbcc_mac u_mac (
		.clk     (clk),
		.s3_load (can_s3),
		.out_load(out_free),
		.window  (window),
		.ctl     (ctl_s2),
		.kernel  (kernel),
		.res     (res)
	);

	assign result.valid = out_v_q;
	assign result.out_red = res.red;
	assign result.out_green = res.green;
	assign result.out_blue = res.blue;
	assign result.frame_last = res.frame_last;

	// The column position always lies inside the current row.
	assert property (@(posedge clk) disable iff (!arst_n) {1'b0, col} < w_eff)
		else $error("column position beyond the frame width");

	// The row position never runs past the flush row.
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row} <= {1'b0, h_eff} + (DIM_W+1)'(1))
		else $error("row position beyond the flush row");

	// A new result only comes out of an occupied product stage.
	assert property (@(posedge clk) disable iff (!arst_n) $rose(out_v_q) |-> $past(s3_v))
		else $error("result appeared without an item in the product stage");

	// A stalled stage-1 item is not lost.
	assert property (@(posedge clk) disable iff (!arst_n) (s1_v && !can_s2) |=> s1_v)
		else $error("stalled stage-1 item dropped");

endmodule

/* rtl/rgbcc_ram.sv */
module rgbcc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/rgbcc_pos.sv */
module rgbcc_pos import rgbcc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rgbcc_cfg_if.sink                    cfg,
	input  logic                         accept,
	output kernel_t                      kernel,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output logic [$clog2(MAX_WIDTH):0]   w_eff,
	output logic [DIM_W-1:0]             row,
	output logic [DIM_W-1:0]             h_eff,
	output tap_ctl_t                     ctl
);

	localparam int CW = $clog2(MAX_WIDTH);

	kernel_t          kernel_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [CW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;
	logic [CW:0]      col_inc;
	logic [DIM_W:0]   h_plus1;
	logic             cfg_write;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	// Frame size clamped into the supported range.
	always_comb begin
		if (width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign h_plus1 = {1'b0, h_eff} + (DIM_W+1)'(1);
	assign col_inc = {1'b0, col_q} + (CW+1)'(1);

	// Centre position of the window and the taps that fall outside the frame.
	// At column zero the centre is the last pixel of the row before the previous one.
	always_comb begin
		ctl = '0;
		if (col_q != '0) begin
			ctl.res = (row_q != '0) && (row_q <= h_eff);
			ctl.left_off = (col_q == CW'(1));
			ctl.right_off = 1'b0;
			ctl.top_off = (row_q == DIM_W'(1));
			ctl.bot_off = (row_q == h_eff);
			ctl.last = 1'b0;
		end else begin
			ctl.res = (row_q >= DIM_W'(2)) && ({1'b0, row_q} <= h_plus1);
			ctl.left_off = (w_eff == (CW+1)'(1));
			ctl.right_off = 1'b1;
			ctl.top_off = (row_q == DIM_W'(2));
			ctl.bot_off = ({1'b0, row_q} == h_plus1);
			ctl.last = ctl.res && ctl.bot_off;
		end
	end

	// Configuration registers; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= '0;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg.index)
				REG_KERNEL_TOP: kernel_q[0] <= cfg.data;
				REG_KERNEL_MID: kernel_q[1] <= cfg.data;
				REG_KERNEL_BOT: kernel_q[2] <= cfg.data;
				REG_IMAGE_WIDTH: width_q <= cfg.data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Raster position of the next item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write && (cfg.index == REG_IMAGE_WIDTH ||
			cfg.index == REG_IMAGE_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ctl.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	assign kernel = kernel_q;
	assign col = col_q;
	assign row = row_q;

endmodule

/* rtl/rgbcc_window.sv */
module rgbcc_window import rgbcc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         s1_v,
	input  logic                         s1_shift,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  rgb_t                         pix,
	input  tap_ctl_t                     ctl,
	output window_t                      window,
	output tap_ctl_t                     ctl_s2
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0] col_s1;
	rgb_t          pix_s1;
	tap_ctl_t      ctl_s1;
	logic          fwd_s1;
	rgb_t          fwd_upper_s1;
	rgb_t          fwd_lower_s1;
	rgb_t          upper_rd;
	rgb_t          lower_rd;
	rgb_t          upper_col;
	rgb_t          lower_col;
	window_t       window_q;
	logic          fwd;

	// Line stores: upper holds the row two behind, lower the row one behind.
	rgbcc_ram #(
		.WIDTH(CHANNELS*PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk  (clk),
		.we   (s1_shift),
		.waddr(col_s1),
		.wdata(lower_col),
		.re   (accept),
		.raddr(col),
		.rdata(upper_rd)
	);

	rgbcc_ram #(
		.WIDTH(CHANNELS*PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lower (
		.clk  (clk),
		.we   (s1_shift),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(col),
		.rdata(lower_rd)
	);

	// A new item that reads the column being written in the same cycle takes the
	// written values directly (one-pixel rows and the first item of a new frame).
	assign fwd = s1_v && (col_s1 == col);
	assign upper_col = fwd_s1 ? fwd_upper_s1 : upper_rd;
	assign lower_col = fwd_s1 ? fwd_lower_s1 : lower_rd;

	// Stage 1: the item waits here for its line store data.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col;
			pix_s1 <= pix;
			ctl_s1 <= ctl;
			fwd_s1 <= fwd;
			fwd_upper_s1 <= lower_col;
			fwd_lower_s1 <= pix_s1;
		end
	end

	// Stage 2: the window shifts left and takes the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_shift) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i][0] <= window_q[i][1];
				window_q[i][1] <= window_q[i][2];
			end
			window_q[0][2] <= upper_col;
			window_q[1][2] <= lower_col;
			window_q[2][2] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_shift) begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign window = window_q;

endmodule

/* rtl/rgbcc_mac.sv */
module rgbcc_mac import rgbcc_pkg::*; (
	input  logic     clk,
	input  logic     s3_load,
	input  logic     out_load,
	input  window_t  window,
	input  tap_ctl_t ctl,
	input  kernel_t  kernel,
	output res_t     res
);

	logic [CHANNELS-1:0][TAPS*TAPS-1:0][ACC_W-1:0] prod_d;
	logic [CHANNELS-1:0][TAPS*TAPS-1:0][ACC_W-1:0] prod_s3;
	logic                                          last_s3;
	logic [CHANNELS-1:0][ACC_W-1:0]                sum;
	res_t                                          res_q;

	// Stage 3 input: one product per tap and channel, zero for taps off the frame.
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int i = 0; i < TAPS; i++) begin
				for (int j = 0; j < TAPS; j++) begin
					if ((i == 0 && ctl.top_off) || (i == TAPS-1 && ctl.bot_off) ||
						(j == 0 && ctl.left_off) || (j == TAPS-1 && ctl.right_off)) begin
						prod_d[ch][i*TAPS+j] = '0;
					end else begin
						prod_d[ch][i*TAPS+j] = mul_tap(kernel[i][PIX_W*j +: PIX_W],
							window[i][j][PIX_W*ch +: PIX_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_load) begin
			prod_s3 <= prod_d;
			last_s3 <= ctl.last;
		end
	end

	// Sum of nine products per channel, wrapping at 16 bits.
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			sum[ch] = (prod_s3[ch][0] + prod_s3[ch][1] + prod_s3[ch][2]) +
				(prod_s3[ch][3] + prod_s3[ch][4] + prod_s3[ch][5]) +
				(prod_s3[ch][6] + prod_s3[ch][7] + prod_s3[ch][8]);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.red <= clamp_pix(sum[0]);
			res_q.green <= clamp_pix(sum[1]);
			res_q.blue <= clamp_pix(sum[2]);
			res_q.frame_last <= last_s3;
		end
	end

	assign res = res_q;

endmodule

/* tb/tb_rgb_3x3_convolution_clamp_core.sv */
`timescale 1ns / 1ps

module tb_rgb_3x3_convolution_clamp_core;
	import rgbcc_pkg::*;

	localparam int RANDOM_ITEMS = 150;

	// Tracks frame position, line stores and window, and queues the expected pixels.
	class conv_tracker;
		logic [CFG_DATA_W-1:0] kernel_rows [TAPS];
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		rgb_t upper_line [MAX_WIDTH_DEF];
		rgb_t lower_line [MAX_WIDTH_DEF];
		rgb_t win [TAPS][TAPS];
		int col_pos;
		int row_pos;
		res_t expected_q [$];
		int errors;

		function new();
			foreach (kernel_rows[i]) kernel_rows[i] = '0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		// A geometry write starts a new frame; kernel writes only swap coefficients.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_KERNEL_TOP: kernel_rows[0] = data;
				REG_KERNEL_MID: kernel_rows[1] = data;
				REG_KERNEL_BOT: kernel_rows[2] = data;
				REG_IMAGE_WIDTH: begin
					width_reg = data[DIM_W-1:0];
					col_pos = 0;
					row_pos = 0;
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = data[DIM_W-1:0];
					col_pos = 0;
					row_pos = 0;
				end
				default: ;
			endcase
		endfunction

		// Advances the stream by one item and queues the centre result it completes.
		function void note_item(logic kind, rgb_t px);
			int w;
			int h;
			int x;
			int y;
			int col;
			int acc;
			rgb_t pix;
			byte cf;
			logic [PIX_W-1:0] p8;
			logic [ACC_W-1:0] a16;
			logic [PIX_W-1:0] chan [CHANNELS];
			bit last;
			res_t exp_res;

			w = int'(width_reg);
			if (w < 1) w = 1;
			if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
			h = int'(height_reg);
			if (h < 1) h = 1;
			if (h > MAX_HEIGHT) h = MAX_HEIGHT;
			pix = (kind == FUNC_PIXEL) ? px : '0;
			col = (col_pos < MAX_WIDTH_DEF) ? col_pos : 0;

			// Shift the window left and bring in the new column.
			for (int i = 0; i < TAPS; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = upper_line[col];
			win[1][2] = lower_line[col];
			win[2][2] = pix;
			upper_line[col] = lower_line[col];
			lower_line[col] = pix;

			// The centre lies one row and one column behind the incoming item.
			if (col_pos > 0) begin
				x = col_pos - 1;
				y = row_pos - 1;
			end else begin
				x = w - 1;
				y = row_pos - 2;
			end

			last = 1'b0;
			if (y >= 0 && y < h && x >= 0 && x < w) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					acc = 0;
					for (int i = 0; i < TAPS; i++) begin
						if ((i == 0 && y == 0) || (i == TAPS - 1 && y == h - 1)) continue;
						for (int j = 0; j < TAPS; j++) begin
							if ((j == 0 && x == 0) || (j == TAPS - 1 && x == w - 1)) continue;
							cf = kernel_rows[i][PIX_W*j +: PIX_W];
							p8 = win[i][j][PIX_W*ch +: PIX_W];
							acc = acc + int'(cf) * int'(p8);
						end
					end
					// Wrap to 16 bits, then clamp to the pixel range.
					a16 = acc[ACC_W-1:0];
					if (a16[ACC_W-1]) begin
						chan[ch] = '0;
					end else if (a16 > PIX_MAX) begin
						chan[ch] = PIX_MAX[PIX_W-1:0];
					end else begin
						chan[ch] = a16[PIX_W-1:0];
					end
				end
				last = (x == w - 1) && (y == h - 1);
				exp_res.red = chan[0];
				exp_res.green = chan[1];
				exp_res.blue = chan[2];
				exp_res.frame_last = last;
				expected_q = {expected_q, exp_res};
			end

			// Raster position of the next item; the frame end wraps to the origin.
			if (last) begin
				col_pos = 0;
				row_pos = 0;
			end else begin
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					row_pos++;
				end
				row_pos = row_pos % (1 << DIM_W);
			end
		endfunction

		// Compares one result transaction with the oldest expected pixel.
		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: out_red %0d out_green %0d out_blue %0d",
					got.red, got.green, got.blue);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red) begin
				$error("out_red: expected %0d, actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("out_green: expected %0d, actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int src_idle_pct;
	int sink_idle_pct;
	int items_sent;
	conv_tracker tracker;

	rgbcc_pix_if pixel_ch ();
	rgbcc_res_if result_ch ();
	rgbcc_cfg_if cfg_ch ();

	rgb_3x3_convolution_clamp_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// Output backpressure.
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Transactions seen at the rising edge feed the tracker.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.index, cfg_ch.data);
			if (pixel_ch.valid && pixel_ch.ready) begin
				tracker.note_item(pixel_ch.func,
					{pixel_ch.pix_blue, pixel_ch.pix_green, pixel_ch.pix_red});
			end
			if (result_ch.valid && result_ch.ready) begin
				tracker.check_result('{red: result_ch.out_red, green: result_ch.out_green,
					blue: result_ch.out_blue, frame_last: result_ch.frame_last});
			end
		end
	end

	// Channel values with a bias toward black and full scale.
	function automatic rgb_t rand_pixel();
		rgb_t px;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			case ($urandom_range(0, 7))
				0: px[PIX_W*ch +: PIX_W] = '0;
				1: px[PIX_W*ch +: PIX_W] = '1;
				default: px[PIX_W*ch +: PIX_W] = PIX_W'($urandom());
			endcase
		end
		return px;
	endfunction

	// Coefficients with a bias toward the signed extremes, plus and minus one, and zero.
	function automatic logic [CFG_DATA_W-1:0] rand_kernel_row();
		logic [CFG_DATA_W-1:0] row;
		for (int j = 0; j < TAPS; j++) begin
			case ($urandom_range(0, 9))
				0: row[PIX_W*j +: PIX_W] = 8'h7F;
				1: row[PIX_W*j +: PIX_W] = 8'h80;
				2: row[PIX_W*j +: PIX_W] = 8'h01;
				3: row[PIX_W*j +: PIX_W] = 8'hFF;
				4: row[PIX_W*j +: PIX_W] = 8'h00;
				default: row[PIX_W*j +: PIX_W] = PIX_W'($urandom());
			endcase
		end
		return row;
	endfunction

	// One pixel channel transaction, after a random number of idle cycles.
	task automatic push_item(input logic kind, input rgb_t px);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.func <= kind;
		pixel_ch.pix_red <= px[PIX_W-1:0];
		pixel_ch.pix_green <= px[2*PIX_W-1:PIX_W];
		pixel_ch.pix_blue <= px[3*PIX_W-1:2*PIX_W];
		do @(posedge clk); while (!pixel_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Width and height with random junk above the 11-bit fields.
	task automatic write_geometry(input int w, input int h);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom());
		word[DIM_W-1:0] = DIM_W'(w);
		write_config(REG_IMAGE_WIDTH, word);
		word = CFG_DATA_W'($urandom());
		word[DIM_W-1:0] = DIM_W'(h);
		write_config(REG_IMAGE_HEIGHT, word);
	endtask

	// Items first..stop-1 of a frame with npix pixels; noise swaps pixel and drain.
	task automatic send_span(input int first, input int stop, input int npix,
		input int noise_pct);
		logic kind;
		for (int k = first; k < stop; k++) begin
			kind = (k < npix) ? FUNC_PIXEL : FUNC_DRAIN;
			if ($urandom_range(0, 99) < noise_pct) kind = ~kind;
			push_item(kind, rand_pixel());
		end
	endtask

	// Waits until every expected pixel is out and the pipeline has emptied.
	task automatic wait_drained();
		pixel_ch.valid <= 1'b0;
		while (tracker.expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int w;
		int h;
		int npix;
		int total;
		int cut;
		int noise;
		int start;
		bit new_geometry;

		tracker = new();
		arst_n = 1'b0;
		pixel_ch.valid = 1'b0;
		pixel_ch.func = FUNC_PIXEL;
		pixel_ch.pix_red = '0;
		pixel_ch.pix_green = '0;
		pixel_ch.pix_blue = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_KERNEL_TOP;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		src_idle_pct = 19;
		sink_idle_pct = 51;
		items_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Identity kernel on a 3x3 frame of black, white and random pixels.
		write_config(REG_KERNEL_TOP, '0);
		write_config(REG_KERNEL_MID, 24'h000100);
		write_config(REG_KERNEL_BOT, '0);
		write_geometry(3, 3);
		for (int k = 0; k < 9; k++) begin
			push_item(FUNC_PIXEL, (k % 3 == 0) ? '1 : ((k % 3 == 1) ? '0 : rand_pixel()));
		end
		send_span(9, 13, 9, 0);
		wait_drained();

		// Largest positive coefficients on a white 2x2 frame, so the sums wrap.
		write_config(REG_KERNEL_TOP, 24'h7F7F7F);
		write_config(REG_KERNEL_MID, 24'h7F7F7F);
		write_config(REG_KERNEL_BOT, 24'h7F7F7F);
		write_geometry(2, 2);
		for (int k = 0; k < 4; k++) push_item(FUNC_PIXEL, '1);
		send_span(4, 7, 4, 0);
		wait_drained();

		// Most negative coefficients on a single white pixel.
		write_config(REG_KERNEL_TOP, 24'h808080);
		write_config(REG_KERNEL_MID, 24'h808080);
		write_config(REG_KERNEL_BOT, 24'h808080);
		write_geometry(1, 1);
		push_item(FUNC_PIXEL, '1);
		push_item(FUNC_DRAIN, '1);
		push_item(FUNC_DRAIN, '0);
		wait_drained();

		// Indexes past the register list must change nothing.
		for (int i = REG_IMAGE_HEIGHT + 1; i < (1 << CFG_IDX_W); i++) begin
			write_config(i[CFG_IDX_W-1:0], '1);
		end

		// Zero width and height act as one; a late pixel lands in the row after the frame.
		write_config(REG_KERNEL_MID, 24'h7F80FF);
		write_geometry(0, 0);
		push_item(FUNC_PIXEL, rand_pixel());
		push_item(FUNC_PIXEL, rand_pixel());
		push_item(FUNC_DRAIN, rand_pixel());
		wait_drained();

		// Oversized width clamps to the widest row; the first centres of the
		// following row only come out if the column count wraps there.
		write_config(REG_KERNEL_TOP, rand_kernel_row());
		write_config(REG_KERNEL_MID, rand_kernel_row());
		write_config(REG_KERNEL_BOT, rand_kernel_row());
		write_geometry((1 << DIM_W) - 1, 1);
		send_span(0, MAX_WIDTH_DEF + 3, MAX_WIDTH_DEF, 0);
		wait_drained();

		// Random frames: mostly whole, some cut short, a few with swapped item kinds.
		start = items_sent;
		new_geometry = 1'b1;
		w = 1;
		h = 1;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ((items_sent - start) * 3 / RANDOM_ITEMS)
				0: begin
					src_idle_pct = 19;
					sink_idle_pct = 51;
				end
				1: begin
					src_idle_pct = 51;
					sink_idle_pct = 19;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase

			if ($urandom_range(0, 2) != 0) write_config(REG_KERNEL_TOP, rand_kernel_row());
			if ($urandom_range(0, 2) != 0) write_config(REG_KERNEL_MID, rand_kernel_row());
			if ($urandom_range(0, 2) != 0) write_config(REG_KERNEL_BOT, rand_kernel_row());
			if ($urandom_range(0, 9) == 0) begin
				write_config(CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1,
					(1 << CFG_IDX_W) - 1)), CFG_DATA_W'($urandom()));
			end

			// Without a geometry write the next frame follows straight on.
			if (new_geometry || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 19))
					0: w = 0;
					1, 2, 3: w = $urandom_range(11, 40);
					default: w = $urandom_range(1, 10);
				endcase
				h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
				write_geometry(w, h);
			end
			npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			total = npix + ((w == 0) ? 1 : w) + 1;
			noise = ($urandom_range(0, 3) == 0) ? 5 : 0;
			new_geometry = 1'b0;

			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, total - 1);
				send_span(0, cut, npix, noise);
				wait_drained();
				if ($urandom_range(0, 1) == 0) begin
					// Kernel change in mid frame; the frame resumes where it stopped.
					write_config(REG_KERNEL_MID, rand_kernel_row());
					send_span(cut, total, npix, noise);
				end else begin
					new_geometry = 1'b1;
				end
			end else begin
				send_span(0, total, npix, noise);
			end
			wait_drained();
		end

		if (tracker.errors == 0) begin
			$display("** rgb_3x3_convolution_clamp_core: PASSED **");
		end else begin
			$display("** rgb_3x3_convolution_clamp_core: FAILED **");
		end
		$finish;
	end

	// Watchdog for a stuck handshake or a missing result.
	initial begin
		#5_000_000;
		$display("** rgb_3x3_convolution_clamp_core: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rgbcc_pkg.sv
rtl/rgbcc_ifs.sv
rtl/rgbcc_ram.sv
rtl/rgbcc_pos.sv
rtl/rgbcc_window.sv
rtl/rgbcc_mac.sv
rtl/rgb_3x3_convolution_clamp_core.sv
tb/tb_rgb_3x3_convolution_clamp_core.sv
